### hw/rtl/u8u16_pkg.sv
package u8u16_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_item;
    logic        last_of_string;
  } out_item_t;

  // One decoded byte as it travels from the front to the back: one or two units.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        two;
    logic        string_end;
  } entry_t;

  localparam logic [15:0] REPL_CHAR      = 16'hFFFD;
  localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
  localparam logic [20:0] BMP_LAST       = 21'h00FFFF;
  localparam logic [20:0] SURR_FIRST     = 21'h00D800;
  localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
  localparam logic [20:0] SUPPL_BASE     = 21'h010000;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] MIN_TWO_BYTE   = 21'd128;
  localparam logic [20:0] MIN_THREE_BYTE = 21'd2048;
  localparam logic [20:0] MIN_FOUR_BYTE  = 21'd65536;
  localparam logic [7:0]  CONT_TOP_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_TOP_BITS  = 8'h80;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

endpackage

### hw/rtl/u8u16_front.sv
module u8u16_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  u8u16_pkg::in_item_t in_item,
  output logic                push,
  output u8u16_pkg::entry_t   entry
);
  import u8u16_pkg::*;

  logic [2:0]  seq_len_r, seq_len_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [20:0] pcp_r, pcp_nxt;

  logic [7:0]  b;
  logic        at_end;
  logic        lead_emit;
  logic [15:0] lead_unit;
  logic [2:0]  lead_len;
  logic [20:0] lead_pcp;

  logic [2:0]  s_len;
  logic [1:0]  s_need;
  logic [20:0] s_pcp;
  logic [1:0]  cnt;
  logic [15:0] u0, u1;
  logic [20:0] cp_cat;
  logic [1:0]  need_dec;
  logic [20:0] cp_min;
  logic [19:0] v;

  assign b      = in_item.data_byte;
  assign at_end = in_item.string_end;

  // Lead byte handling, shared by the idle case and the interrupted-sequence case.
  always_comb begin
    lead_emit = 1'b0;
    lead_unit = REPL_CHAR;
    lead_len  = LEN_NONE;
    lead_pcp  = '0;
    if (!b[7]) begin
      lead_emit = 1'b1;
      lead_unit = {8'h00, b};
    end else if (at_end) begin
      lead_emit = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      lead_len = LEN_TWO;
      lead_pcp = {16'h0000, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len = LEN_THREE;
      lead_pcp = {17'h00000, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len = LEN_FOUR;
      lead_pcp = {18'h00000, b[2:0]};
    end else begin
      lead_emit = 1'b1;
    end
  end

  assign cp_cat   = {pcp_r[14:0], b[5:0]};
  assign need_dec = need_r - 2'd1;
  assign v        = cp_cat[19:0] - SUPPL_BASE[19:0];

  always_comb begin
    case (seq_len_r)
      LEN_TWO:   cp_min = MIN_TWO_BYTE;
      LEN_THREE: cp_min = MIN_THREE_BYTE;
      default:   cp_min = MIN_FOUR_BYTE;
    endcase
  end

  always_comb begin
    s_len  = seq_len_r;
    s_need = need_r;
    s_pcp  = pcp_r;
    cnt    = 2'd0;
    u0     = REPL_CHAR;
    u1     = REPL_CHAR;
    if (seq_len_r == LEN_NONE) begin
      if (lead_emit) begin
        cnt = 2'd1;
        u0  = lead_unit;
      end else begin
        s_len  = lead_len;
        s_need = 2'(lead_len - 3'd1);
        s_pcp  = lead_pcp;
      end
    end else if ((b & CONT_TOP_MASK) == CONT_TOP_BITS) begin
      if (need_dec == 2'd0) begin
        s_len  = LEN_NONE;
        s_need = '0;
        s_pcp  = '0;
        if (cp_cat < cp_min || cp_cat > MAX_CODE_POINT ||
            (cp_cat >= SURR_FIRST && cp_cat <= SURR_LAST)) begin
          cnt = 2'd1;
        end else if (cp_cat <= BMP_LAST) begin
          cnt = 2'd1;
          u0  = cp_cat[15:0];
        end else begin
          cnt = 2'd2;
          u0  = HIGH_SURR_BASE + {6'd0, v[19:10]};
          u1  = LOW_SURR_BASE + {6'd0, v[9:0]};
        end
      end else if (at_end) begin
        s_len  = LEN_NONE;
        s_need = '0;
        s_pcp  = '0;
        cnt    = 2'd1;
      end else begin
        s_pcp  = cp_cat;
        s_need = need_dec;
      end
    end else begin
      // The sequence is broken off; the same byte then starts over as a lead.
      s_len  = LEN_NONE;
      s_need = '0;
      s_pcp  = '0;
      if (lead_emit) begin
        cnt = 2'd2;
        u1  = lead_unit;
      end else begin
        cnt    = 2'd1;
        s_len  = lead_len;
        s_need = 2'(lead_len - 3'd1);
        s_pcp  = lead_pcp;
      end
    end
  end

  assign seq_len_nxt = accept ? s_len  : seq_len_r;
  assign need_nxt    = accept ? s_need : need_r;
  assign pcp_nxt     = accept ? s_pcp  : pcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= LEN_NONE;
      need_r    <= '0;
      pcp_r     <= '0;
    end else begin
      seq_len_r <= seq_len_nxt;
      need_r    <= need_nxt;
      pcp_r     <= pcp_nxt;
    end
  end

  assign push             = accept && (cnt != 2'd0);
  assign entry.unit0      = u0;
  assign entry.unit1      = u1;
  assign entry.two        = (cnt == 2'd2);
  assign entry.string_end = at_end;

endmodule

### hw/rtl/u8u16_queue.sv
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8u16_pkg::entry_t wr_entry,
  output logic              full,
  input  logic              pop,
  output u8u16_pkg::entry_t rd_entry,
  output logic              empty
);
  import u8u16_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

### hw/rtl/u8u16_back.sv
module u8u16_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u8u16_pkg::entry_t    head,
  input  logic                 head_valid,
  output logic                 head_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output u8u16_pkg::out_item_t out_item
);
  import u8u16_pkg::*;

  logic      second_r, second_nxt;
  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic      slot_free;
  logic      take;
  logic      is_last;

  assign slot_free = !valid_r || out_pop;
  assign take      = head_valid && slot_free;
  assign is_last   = second_r || !head.two;
  assign head_pop  = take && is_last;

  always_comb begin
    second_nxt = second_r;
    valid_nxt  = valid_r;
    item_nxt   = item_r;
    if (take) begin
      valid_nxt               = 1'b1;
      item_nxt.code_unit      = second_r ? head.unit1 : head.unit0;
      item_nxt.last_of_item   = is_last;
      item_nxt.last_of_string = is_last && head.string_end;
      second_nxt              = !is_last;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      second_r <= second_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_empty = !valid_r;
  assign out_item  = item_r;

endmodule

### hw/rtl/utf8_to_utf16_transcoder_unit.sv
// A byte accepted at a clock edge is decoded combinationally into the queue at that
// edge; its first code unit then moves from the queue head into the output register
// once that register is free. Throughput: one byte per cycle in while in_full is low,
// one code unit per cycle out while out_pop is high; a byte that makes a surrogate
// pair or a replacement plus a character gives two code units.
// Reset (synchronous, rst_n low): no sequence open, queue empty, no result waiting.
module utf8_to_utf16_transcoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  u8u16_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output u8u16_pkg::out_item_t out_item
);
  import u8u16_pkg::*;

  logic   accept;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wr, q_rd;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  u8u16_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .push    (q_push),
    .entry   (q_wr)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_rd),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("front pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  a_string_end_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.last_of_string) |-> out_item.last_of_item)
    else $error("last_of_string without last_of_item");

endmodule
